FILE: hw/rtl/aob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Shared widths, constants and payload types of the source-over blender.
// ----------------------------------------------------------------------------
package aob_pkg;

    // Channel and datapath widths.
    localparam int CH_W   = 8;
    localparam int SA_W   = 16;
    localparam int WGT_W  = 24;
    localparam int NUM_W  = 32;
    localparam int Q_W    = 8;
    localparam int COLORS = 3;

    // Pipeline shape: weight front end, then one quotient bit per stage.
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STEPS    = Q_W;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS;

    // K = 255 * 255, the full-scale product of two 8-bit alphas.
    localparam logic [SA_W-1:0] BLEND_K       = 16'd65025;
    localparam logic [CH_W-1:0] OPACITY_RESET = 8'd255;

    // One RGBA8 pixel.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix;

    // State of one pixel inside the divider pipeline.
    // Color lane 0 is red, 1 is green, 2 is blue.
    typedef struct packed {
        logic [COLORS-1:0][NUM_W-1:0] rem;
        logic [WGT_W-1:0]             den;
        logic [WGT_W-1:0]             arem;
        logic [COLORS-1:0][Q_W-1:0]   quo;
        logic [Q_W-1:0]               aquo;
        logic                         zero;
        t_pix                         dst;
    } t_div;

endpackage

FILE: hw/rtl/aob_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend input channel
// Valid/ready channel carrying one source and one destination RGBA8 pixel.
// ----------------------------------------------------------------------------
interface aob_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha,
        output dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );

    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha,
        input  dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

FILE: hw/rtl/aob_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend output channel
// Valid/ready channel carrying one composited RGBA8 pixel.
// ----------------------------------------------------------------------------
interface aob_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

FILE: hw/rtl/aob_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend weight front end
// Four pipeline stages that form the blend weights, the denominator and the
// three color numerators. All terms are divided by 255 against the textbook
// form, which leaves every quotient unchanged:
//   A = src_alpha * opacity * 255, B = dst_alpha * (K - src_alpha * opacity)
//   den = A + B, num_c = s_c * A + d_c * B
// ----------------------------------------------------------------------------
module aob_weight (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aob_pkg::t_pix i_src,
    input  aob_pkg::t_pix i_dst,
    input  logic [7:0]    i_opacity,
    output logic          o_valid,
    input  logic          i_ready,
    output aob_pkg::t_div o_div
);
    import aob_pkg::*;

    // Per-stage valid bits and stage-ready chain.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: scaled source alpha.
    t_pix            r_src1, r_dst1;
    logic [SA_W-1:0] r_sa1;
    logic [SA_W-1:0] n_sa1;

    assign n_sa1 = SA_W'(i_src.alpha) * SA_W'(i_opacity);

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_src1 <= i_src;
            r_dst1 <= i_dst;
            r_sa1  <= n_sa1;
        end
    end

    // Stage 2: source and destination weights.
    t_pix             r_src2, r_dst2;
    logic [WGT_W-1:0] r_a2, r_b2;
    logic [WGT_W-1:0] n_a2, n_b2;

    assign n_a2 = {r_sa1, 8'd0} - WGT_W'(r_sa1);
    assign n_b2 = WGT_W'(r_dst1.alpha) * WGT_W'(BLEND_K - r_sa1);

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_src2 <= r_src1;
            r_dst2 <= r_dst1;
            r_a2   <= n_a2;
            r_b2   <= n_b2;
        end
    end

    // Stage 3: weighted color products and the denominator.
    logic [COLORS-1:0][CH_W-1:0]  w_s2, w_d2;
    logic [COLORS-1:0][NUM_W-1:0] n_ps3, n_pd3, r_ps3, r_pd3;
    logic [WGT_W:0]               n_den_sum3;
    logic [WGT_W-1:0]             r_den3;
    t_pix                         r_dst3;

    assign w_s2       = {r_src2.blue, r_src2.green, r_src2.red};
    assign w_d2       = {r_dst2.blue, r_dst2.green, r_dst2.red};
    assign n_den_sum3 = {1'b0, r_a2} + {1'b0, r_b2};

    always_comb begin
        for (int c = 0; c < COLORS; c++) begin
            n_ps3[c] = NUM_W'(w_s2[c]) * NUM_W'(r_a2);
            n_pd3[c] = NUM_W'(w_d2[c]) * NUM_W'(r_b2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_ps3  <= n_ps3;
            r_pd3  <= n_pd3;
            r_den3 <= n_den_sum3[WGT_W-1:0];
            r_dst3 <= r_dst2;
        end
    end

    // Stage 4: numerators; the divider starts from these remainders.
    t_div             n_div4, r_div4;
    logic [NUM_W:0]   w_num_sum [COLORS];

    always_comb begin
        n_div4 = '0;
        for (int c = 0; c < COLORS; c++) begin
            w_num_sum[c]  = {1'b0, r_ps3[c]} + {1'b0, r_pd3[c]};
            n_div4.rem[c] = w_num_sum[c][NUM_W-1:0];
        end
        n_div4.den  = r_den3;
        n_div4.arem = r_den3;
        n_div4.zero = (r_den3 == '0);
        n_div4.dst  = r_dst3;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_div4 <= n_div4;
        end
    end

    assign o_valid = r_v4;
    assign o_div   = r_div4;

endmodule

FILE: hw/rtl/aob_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend divider step
// One restoring-division stage: settles quotient bit SHIFT of the three
// color lanes (divisor den) and of the alpha lane (divisor K).
// ----------------------------------------------------------------------------
module aob_div_step #(
    parameter int SHIFT = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aob_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output aob_pkg::t_div o_div
);
    import aob_pkg::*;

    logic             r_v;
    t_div             r_div, n_div;
    logic [NUM_W-1:0] w_dsh;
    logic [WGT_W-1:0] w_ksh;

    assign o_ready = !r_v || i_ready;

    // Divisors aligned to this quotient bit.
    assign w_dsh = NUM_W'(i_div.den) << SHIFT;
    assign w_ksh = WGT_W'(BLEND_K) << SHIFT;

    // Compare and subtract in every lane.
    always_comb begin
        n_div = i_div;
        for (int c = 0; c < COLORS; c++) begin
            if (i_div.rem[c] >= w_dsh) begin
                n_div.rem[c]        = i_div.rem[c] - w_dsh;
                n_div.quo[c][SHIFT] = 1'b1;
            end
        end
        if (i_div.arem >= w_ksh) begin
            n_div.arem        = i_div.arem - w_ksh;
            n_div.aquo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_v;
    assign o_div   = r_div;

endmodule

FILE: hw/rtl/alpha_over_pixel_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over pixel blend, top level
// Straight-alpha source-over compositing of one RGBA8 pixel pair per transfer.
// ----------------------------------------------------------------------------
// The block takes one source/destination pixel pair per clock while the input
// is ready and returns the composited pixel: four stages form the weights and
// the numerators, and eight restoring-division stages settle one quotient bit
// each. Every stage has its own valid bit and a stall ripples back only as
// far as the first empty stage, so the input keeps accepting while a result
// waits at the output, until the 12 stages are full. The source alpha is
// scaled by the opacity register (value/255, reset 255); write it only while
// no pixel is in flight. When both the scaled source alpha and the
// destination alpha are zero, the destination pixel passes through unchanged.
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    aob_in_if.sink    i_pix,
    aob_out_if.source o_pix
);
    import aob_pkg::*;

    // Opacity register.
    logic [CH_W-1:0] r_opacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= OPACITY_RESET;
        end else if (i_cfg_we) begin
            r_opacity <= i_cfg_wdata;
        end
    end

    // Gather the input pixels.
    t_pix w_src, w_dst;

    assign w_src = '{alpha: i_pix.src_alpha, blue: i_pix.src_blue,
                     green: i_pix.src_green, red: i_pix.src_red};
    assign w_dst = '{alpha: i_pix.dst_alpha, blue: i_pix.dst_blue,
                     green: i_pix.dst_green, red: i_pix.dst_red};

    // Chain between the front end and the divider stages.
    t_div w_div [DIV_STEPS+1];
    logic w_v   [DIV_STEPS+1];
    logic w_r   [DIV_STEPS+1];

    aob_weight u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_src     (w_src),
        .i_dst     (w_dst),
        .i_opacity (r_opacity),
        .o_valid   (w_v[0]),
        .i_ready   (w_r[0]),
        .o_div     (w_div[0])
    );

    // Restoring divider, most significant quotient bit first.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        aob_div_step #(
            .SHIFT (DIV_STEPS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_div   (w_div[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // Result: quotients, or the destination pixel when coverage is zero.
    t_div w_res;

    assign w_res           = w_div[DIV_STEPS];
    assign w_r[DIV_STEPS]  = o_pix.ready;
    assign o_pix.valid     = w_v[DIV_STEPS];
    assign o_pix.out_red   = w_res.zero ? w_res.dst.red   : w_res.quo[0];
    assign o_pix.out_green = w_res.zero ? w_res.dst.green : w_res.quo[1];
    assign o_pix.out_blue  = w_res.zero ? w_res.dst.blue  : w_res.quo[2];
    assign o_pix.out_alpha = w_res.zero ? w_res.dst.alpha : w_res.aquo;

endmodule

FILE: hw/rtl/aob_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend port checker
// Watches the top-level channels: tracks pixels in flight and checks the
// output against them and against the pipeline's ready behavior.
// ----------------------------------------------------------------------------
module aob_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    import aob_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic             w_in_xfer, w_out_xfer;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;
    assign n_cnt      = r_cnt + CNT_W'(w_in_xfer) - CNT_W'(w_out_xfer);

    // Pixels accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A result is only shown for a pixel that was taken in.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != '0))
        else $error("output valid with no pixel in flight");

    // The pipeline never holds more pixels than it has stages.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    // With the output free, no stage can be blocked, so the input is ready.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output is free");

    // A stalled result stays and keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output changed");

endmodule

bind alpha_over_pixel_blend_top aob_chk u_aob_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  ({o_pix.out_alpha, o_pix.out_blue, o_pix.out_green, o_pix.out_red})
);

FILE: tb/alpha_over_pixel_blend_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over pixel blend testbench
// Drives source/destination pixel pairs through the blender under random
// idling and stalls, predicts every composited pixel with exact integer math
// at the current opacity, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend_top_test;
    import aob_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 8;
    localparam int REPORT_MAX   = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int CASES        = 20;

    // One row of the directed table; the literal result is used when lit is set.
    typedef struct {
        logic [7:0] op;
        logic [7:0] sr, sg, sb, sa;
        logic [7:0] dr, dg, db, da;
        bit         lit;
        logic [7:0] er, eg, eb, ea;
    } t_case;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    aob_in_if  pix_in ();
    aob_out_if pix_out ();

    // Expected composited pixels, oldest first, and the opacity they assume.
    t_pix       pending_blends [$];
    logic [7:0] cur_opacity;

    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  src_gaps    = 1'b1;
    bit  sink_stalls = 1'b1;
    bit  hold_req    = 1'b0;

    // Directed rows: opaque source, zero coverage, transparent source, extremes.
    t_case directed_cases [CASES] = '{
        '{255,  10,  20,  30, 255, 200, 100,  50, 128, 1'b1,  10,  20,  30, 255},
        '{255, 255, 255, 255, 255,   0,   0,   0,   0, 1'b1, 255, 255, 255, 255},
        '{255,   0,   0,   0, 255, 255, 255, 255, 255, 1'b1,   0,   0,   0, 255},
        '{255,   1,   2,   3,   0,   9,   8,   7,   0, 1'b1,   9,   8,   7,   0},
        '{255, 255, 255, 255,   0, 255, 255, 255,   0, 1'b1, 255, 255, 255,   0},
        '{255,  77,  88,  99,   0,  11,  22,  33, 255, 1'b1,  11,  22,  33, 255},
        '{255, 255,   0, 255, 128,   0, 255,   0, 128, 1'b0,   0,   0,   0,   0},
        '{255, 200, 150, 100,   1,  50,  60,  70, 255, 1'b0,   0,   0,   0,   0},
        '{255,   0, 255,   0, 254, 255,   0, 255,   1, 1'b0,   0,   0,   0,   0},
        '{255, 128, 128, 128, 128, 128, 128, 128,   0, 1'b0,   0,   0,   0,   0},
        '{255, 255, 255, 255,   1,   0,   0,   0,   0, 1'b0,   0,   0,   0,   0},
        '{  0,  10,  20,  30, 255,   1,   2,   3,   0, 1'b1,   1,   2,   3,   0},
        '{  0, 255, 255, 255, 255,  40,  50,  60, 200, 1'b1,  40,  50,  60, 200},
        '{  1, 255, 255, 255, 255,   0,   0,   0,   0, 1'b0,   0,   0,   0,   0},
        '{  1, 255,   0, 128, 255,   0, 255, 128, 255, 1'b0,   0,   0,   0,   0},
        '{128, 255, 255, 255, 255,   0,   0,   0, 255, 1'b0,   0,   0,   0,   0},
        '{128,   0,   0,   0,   0, 255, 255, 255,   0, 1'b1, 255, 255, 255,   0},
        '{254, 255, 128,   1, 255,   1, 128, 255, 255, 1'b0,   0,   0,   0,   0},
        '{254,  17,  34,  51, 200,  99,  98,  97,  50, 1'b0,   0,   0,   0,   0},
        '{255, 255, 255, 255, 255, 255, 255, 255, 255, 1'b1, 255, 255, 255, 255}
    };

    // Opacity of each random phase; a negative entry picks a random value.
    int phase_opacity [PHASES] = '{0, 1, 128, 254, -1, -1, 255, -1};

    alpha_over_pixel_blend_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    always #CLK_HALF clk = ~clk;

    // Weighted mean of one color channel, truncated.
    function automatic logic [7:0] mix_channel(logic [63:0] s, logic [63:0] d,
                                               logic [63:0] w_src, logic [63:0] w_dst,
                                               logic [63:0] den);
        return 8'((s * w_src + d * w_dst) / den);
    endfunction

    // Exact source-over of one pixel pair at the given opacity.
    function automatic t_pix blend_over(t_pix src, t_pix dst, logic [7:0] op);
        logic [63:0] k, sa, dd, w_src, w_dst, den;
        t_pix        res;
        k     = 64'(BLEND_K);
        sa    = 64'(src.alpha) * 64'(op);
        dd    = 64'(dst.alpha) * 64'd255;
        w_src = sa * k;
        w_dst = dd * (k - sa);
        den   = w_src + w_dst;
        // With no coverage at all the destination passes through.
        if (den == 64'd0) begin
            return dst;
        end
        res.red   = mix_channel(64'(src.red), 64'(dst.red), w_src, w_dst, den);
        res.green = mix_channel(64'(src.green), 64'(dst.green), w_src, w_dst, den);
        res.blue  = mix_channel(64'(src.blue), 64'(dst.blue), w_src, w_dst, den);
        res.alpha = 8'((64'd255 * den) / (k * k));
        return res;
    endfunction

    // Alpha that favors the fully transparent and fully opaque ends.
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel pair and wait for its transfer; the expectation is
    // queued at the accepting edge.
    task automatic send_pixel(input t_pix src, input t_pix dst,
                              input bit lit, input t_pix lit_pix);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.src_red   <= src.red;
        pix_in.src_green <= src.green;
        pix_in.src_blue  <= src.blue;
        pix_in.src_alpha <= src.alpha;
        pix_in.dst_red   <= dst.red;
        pix_in.dst_green <= dst.green;
        pix_in.dst_blue  <= dst.blue;
        pix_in.dst_alpha <= dst.alpha;
        pix_in.valid     <= 1'b1;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        pending_blends.push_back(lit ? lit_pix : blend_over(src, dst, cur_opacity));
    endtask

    // Let the pipeline empty, then write the opacity register.
    task automatic set_opacity(input logic [7:0] op);
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_blends.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= op;
        cur_opacity  = op;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side ready: random stall bursts, one long hold on request.
    initial begin
        forever begin
            if (hold_req) begin
                pix_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end else begin
                pix_out.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result transfer against the oldest expectation.
    always @(posedge clk) begin
        t_pix got, want;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            got.red   = pix_out.out_red;
            got.green = pix_out.out_green;
            got.blue  = pix_out.out_blue;
            got.alpha = pix_out.out_alpha;
            if (pending_blends.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $realtime,
                             got.red, got.green, got.blue, got.alpha);
                end
            end else begin
                want = pending_blends.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                                 $realtime, want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, then random phases at several opacities.
    initial begin
        t_pix src, dst, lit_pix;
        int   op;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 8'd0;
        pix_in.valid     <= 1'b0;
        pix_in.src_red   <= 8'd0;
        pix_in.src_green <= 8'd0;
        pix_in.src_blue  <= 8'd0;
        pix_in.src_alpha <= 8'd0;
        pix_in.dst_red   <= 8'd0;
        pix_in.dst_green <= 8'd0;
        pix_in.dst_blue  <= 8'd0;
        pix_in.dst_alpha <= 8'd0;
        cur_opacity       = OPACITY_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the opacity is rewritten whenever a row asks for another.
        foreach (directed_cases[i]) begin
            if (directed_cases[i].op != cur_opacity) begin
                set_opacity(directed_cases[i].op);
            end
            src     = '{alpha: directed_cases[i].sa, blue: directed_cases[i].sb,
                        green: directed_cases[i].sg, red: directed_cases[i].sr};
            dst     = '{alpha: directed_cases[i].da, blue: directed_cases[i].db,
                        green: directed_cases[i].dg, red: directed_cases[i].dr};
            lit_pix = '{alpha: directed_cases[i].ea, blue: directed_cases[i].eb,
                        green: directed_cases[i].eg, red: directed_cases[i].er};
            send_pixel(src, dst, directed_cases[i].lit, lit_pix);
        end

        // Random phases; the last one runs with no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            op = (phase_opacity[p] < 0) ? $urandom_range(0, 255) : phase_opacity[p];
            set_opacity(8'(op));
            if (p == PHASES - 1) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mid-run, hold the result side off so the pipeline backs up.
                if (p == 2 && n == 60) begin
                    hold_req = 1'b1;
                end
                src.red   = 8'($urandom_range(0, 255));
                src.green = 8'($urandom_range(0, 255));
                src.blue  = 8'($urandom_range(0, 255));
                src.alpha = pick_alpha();
                dst.red   = 8'($urandom_range(0, 255));
                dst.green = 8'($urandom_range(0, 255));
                dst.blue  = 8'($urandom_range(0, 255));
                dst.alpha = pick_alpha();
                send_pixel(src, dst, 1'b0, src);
            end
        end

        // Drain, then watch a while longer for stray results.
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_blends.size() != 0) @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
